FILE: hw/rtl/grow_only_counter_replica_macros.svh
// ----------------------------------------------------------------------------
// Grow-only counter replica assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GROW_ONLY_COUNTER_REPLICA_MACROS_SVH
`define GROW_ONLY_COUNTER_REPLICA_MACROS_SVH

// Same-cycle implication.
`define GCR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg
// Constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package gcr_pkg;

  localparam int NODE_SLOTS = 64;
  localparam int NODE_W     = 6;
  localparam int CNT_W      = 64;
  localparam int NTOT_W     = 7;
  localparam int ACT_W      = $clog2(NODE_SLOTS + 1);

  typedef enum logic [2:0] {
    MODE_CLEAR   = 3'd0,
    MODE_ADD     = 3'd1,
    MODE_READ    = 3'd2,
    MODE_TOTAL   = 3'd3,
    MODE_MERGE   = 3'd4,
    MODE_COMPARE = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_WINIT,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic latch;
    logic mem_rd;
    logic exec;
    logic walk_init;
    logic walk_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic cmp_last;
    logic walk_done;
  } dp_status_t;

endpackage

FILE: hw/rtl/gcr_ctrl.sv
// ----------------------------------------------------------------------------
// gcr_ctrl
// Sequencing state machine: decodes a request and steps the datapath.
// ----------------------------------------------------------------------------
`include "grow_only_counter_replica_macros.svh"

module gcr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic [2:0]           mode_i,
  input  gcr_pkg::dp_status_t  status_i,
  output gcr_pkg::dp_cmd_t     cmd_o,
  output logic                 busy
);
  import gcr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (mode_e'(mode_i)) inside
            MODE_TOTAL: state_d = ST_WINIT;
            MODE_ADD, MODE_READ, MODE_MERGE, MODE_COMPARE: state_d = ST_READ;
            default: state_d = ST_EXEC;
          endcase
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        state_d = status_i.cmp_last ? ST_WINIT : ST_IDLE;
      end
      ST_WINIT: state_d = ST_WALK;
      ST_WALK: begin
        if (status_i.walk_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:  cmd_o.latch     = start;
      ST_READ:  cmd_o.mem_rd    = 1'b1;
      ST_EXEC:  cmd_o.exec      = 1'b1;
      ST_WINIT: cmd_o.walk_init = 1'b1;
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        cmd_o.finish    = status_i.walk_done;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  `GCR_ASSERT_NEXT(a_start_leaves_idle, state_q == ST_IDLE && start, state_q != ST_IDLE, "accepted request did not start")
  `GCR_ASSERT_NEXT(a_walk_end_idle, state_q == ST_WALK && status_i.walk_done, state_q == ST_IDLE && !busy, "walk end did not release the block")

endmodule

FILE: hw/rtl/gcr_dpath.sv
// ----------------------------------------------------------------------------
// gcr_dpath
// Count memory, active count, compare flags, walk counter and result register.
// ----------------------------------------------------------------------------
`include "grow_only_counter_replica_macros.svh"

module gcr_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gcr_pkg::dp_cmd_t            cmd_i,
  output gcr_pkg::dp_status_t         status_o,
  input  logic [2:0]                  mode_i,
  input  logic [gcr_pkg::NODE_W-1:0]  node_i,
  input  logic [gcr_pkg::CNT_W-1:0]   amount_i,
  input  logic [gcr_pkg::NTOT_W-1:0]  node_total_i,
  input  logic                        last_i,
  output logic [gcr_pkg::CNT_W-1:0]   count_value_o,
  output logic                        accepted_o,
  output logic [1:0]                  order_o,
  output logic                        order_valid_o,
  output logic                        done_o
);
  import gcr_pkg::*;

  // Latched request.
  mode_e               mode_q;
  logic [NODE_W-1:0]   node_q;
  logic [CNT_W-1:0]    amount_q;
  logic [NTOT_W-1:0]   total_q;
  logic                last_q;

  // Count storage; an entry without its valid bit reads as zero.
  logic [CNT_W-1:0]      counts_mem [NODE_SLOTS];
  logic [NODE_SLOTS-1:0] valid_q;
  logic [CNT_W-1:0]      rdata_q;
  logic                  rvld_q;

  logic [ACT_W-1:0] active_q, active_d;
  logic             smaller_q, smaller_d;
  logic             larger_q, larger_d;
  logic [ACT_W-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] sum_q, sum_d;

  logic [CNT_W-1:0]  count_q;
  logic              acc_q;
  logic [1:0]        order_q;
  logic              ovld_q;
  logic              done_q;

  logic              wr_en;
  logic [CNT_W-1:0]  wdata;
  logic              clr_all;
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  logic              issue;
  logic [CNT_W-1:0]  mine;
  logic [CNT_W-1:0]  cmp_val;
  logic              in_range;
  logic [ACT_W-1:0]  tot_c;
  logic              emit;
  logic [CNT_W-1:0]  res_count;
  logic              res_acc;
  logic [1:0]        res_order;
  logic              res_ovld;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q   <= mode_e'(mode_i);
      node_q   <= node_i;
      amount_q <= amount_i;
      total_q  <= node_total_i;
      last_q   <= last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      counts_mem[node_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= counts_mem[rd_addr];
    end
  end

  assign issue   = idx_q < active_q;
  assign rd_en   = cmd_i.mem_rd | (cmd_i.walk_step & issue);
  assign rd_addr = cmd_i.mem_rd ? node_q : idx_q[NODE_W-1:0];

  assign mine     = rvld_q ? rdata_q : '0;
  assign in_range = {1'b0, node_q} < active_q;
  assign cmp_val  = in_range ? mine : '0;
  assign tot_c    = (ACT_W'(total_q) > ACT_W'(NODE_SLOTS)) ? ACT_W'(NODE_SLOTS)
                                                            : ACT_W'(total_q);

  assign status_o.cmp_last  = (mode_q == MODE_COMPARE) && last_q;
  assign status_o.walk_done = (idx_q >= active_q) && !pend_q;

  always_comb begin
    wr_en     = 1'b0;
    wdata     = mine + amount_q;
    clr_all   = 1'b0;
    active_d  = active_q;
    smaller_d = smaller_q;
    larger_d  = larger_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    sum_d     = sum_q;
    emit      = 1'b0;
    res_count = '0;
    res_acc   = 1'b0;
    res_order = 2'b00;
    res_ovld  = 1'b0;

    if (cmd_i.exec) begin
      emit = !status_o.cmp_last;
      case (mode_q)
        MODE_CLEAR: begin
          clr_all   = 1'b1;
          active_d  = tot_c;
          smaller_d = 1'b0;
          larger_d  = 1'b0;
          res_acc   = 1'b1;
        end
        MODE_ADD: begin
          if (in_range) begin
            wr_en   = 1'b1;
            res_acc = 1'b1;
          end
        end
        MODE_READ: begin
          if (in_range) begin
            res_count = mine;
            res_acc   = 1'b1;
          end
        end
        MODE_MERGE: begin
          wr_en   = 1'b1;
          wdata   = (amount_q > mine) ? amount_q : mine;
          res_acc = 1'b1;
          if (last_q && (tot_c > active_q)) begin
            active_d = tot_c;
          end
        end
        MODE_COMPARE: begin
          if (cmp_val < amount_q) begin
            smaller_d = 1'b1;
          end
          if (cmp_val > amount_q) begin
            larger_d = 1'b1;
          end
          res_acc = 1'b1;
        end
        default: ;
      endcase
    end

    if (cmd_i.walk_init) begin
      idx_d  = (mode_q == MODE_TOTAL) ? '0 : tot_c;
      sum_d  = '0;
      pend_d = 1'b0;
    end

    if (cmd_i.walk_step) begin
      if (issue) begin
        idx_d = idx_q + ACT_W'(1);
      end
      pend_d = issue;
      if (pend_q) begin
        sum_d = sum_q + mine;
        // Stored entries past the other replica's length compare against zero.
        if ((mode_q == MODE_COMPARE) && (mine != '0)) begin
          larger_d = 1'b1;
        end
      end
    end

    if (cmd_i.finish) begin
      emit    = 1'b1;
      res_acc = 1'b1;
      if (mode_q == MODE_COMPARE) begin
        res_order = {larger_q, smaller_q};
        res_ovld  = 1'b1;
        smaller_d = 1'b0;
        larger_d  = 1'b0;
      end else begin
        res_count = sum_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rvld_q    <= 1'b0;
      active_q  <= '0;
      smaller_q <= 1'b0;
      larger_q  <= 1'b0;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      sum_q     <= '0;
      count_q   <= '0;
      acc_q     <= 1'b0;
      order_q   <= 2'b00;
      ovld_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (clr_all) begin
        valid_q <= '0;
      end else if (wr_en) begin
        valid_q[node_q] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= valid_q[rd_addr];
      end
      active_q  <= active_d;
      smaller_q <= smaller_d;
      larger_q  <= larger_d;
      idx_q     <= idx_d;
      pend_q    <= pend_d;
      sum_q     <= sum_d;
      done_q    <= emit;
      if (emit) begin
        count_q <= res_count;
        acc_q   <= res_acc;
        order_q <= res_order;
        ovld_q  <= res_ovld;
      end
    end
  end

  assign count_value_o = count_q;
  assign accepted_o    = acc_q;
  assign order_o       = order_q;
  assign order_valid_o = ovld_q;
  assign done_o        = done_q;

  `GCR_ASSERT_IMPL(a_active_bound, 1'b1, active_q <= ACT_W'(NODE_SLOTS), "active count above table size")
  `GCR_ASSERT_IMPL(a_order_accepted, order_valid_o, accepted_o && count_value_o == '0, "order result malformed")
  `GCR_ASSERT_NEXT(a_finish_emits, cmd_i.finish, done_o, "walk finish produced no result")

endmodule

FILE: hw/rtl/grow_only_counter_replica.sv
// ----------------------------------------------------------------------------
// grow_only_counter_replica
// One replica of a grow-only counter: per-node 64-bit counts and active count.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low; the block then
// holds busy until its work is done and shows exactly one result on the
// result ports for one cycle, marked by done_o, which the receiver must take
// in that cycle because nothing can hold it off. Clear and the unused mode
// codes go from the accepting edge straight to one execute step and then to
// the result strobe. Add, read entry, merge entry and compare entry first do
// one read of the count memory and then one execute step. Read total walks
// the count memory one entry per cycle behind a registered read. The last
// compare entry additionally walks the stored entries from the other
// replica's node count up to active_nodes. busy drops in the cycle the
// result is shown, so a new request may be issued then. Reset clears every
// entry at once through per-entry valid bits, so no clearing pass follows
// reset.
`include "grow_only_counter_replica_macros.svh"

module grow_only_counter_replica (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  mode_i,
  input  logic [gcr_pkg::NODE_W-1:0]  node_i,
  input  logic [gcr_pkg::CNT_W-1:0]   amount_i,
  input  logic [gcr_pkg::NTOT_W-1:0]  node_total_i,
  input  logic                        last_i,
  output logic                        done_o,
  output logic [gcr_pkg::CNT_W-1:0]   count_value_o,
  output logic                        accepted_o,
  output logic [1:0]                  order_o,
  output logic                        order_valid_o
);
  import gcr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences each request; the datapath owns all counts, flags and results.
  gcr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .mode_i   (mode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  gcr_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .mode_i        (mode_i),
    .node_i        (node_i),
    .amount_i      (amount_i),
    .node_total_i  (node_total_i),
    .last_i        (last_i),
    .count_value_o (count_value_o),
    .accepted_o    (accepted_o),
    .order_o       (order_o),
    .order_valid_o (order_valid_o),
    .done_o        (done_o)
  );

  // The result strobe never lasts longer than one cycle.
  `GCR_ASSERT_NEXT(a_strobe_single, done_o, !done_o, "result strobe lasted more than one cycle")

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grow-only counter replica: requests go in over
// the start/busy handshake, a shadow replica predicts every result, and each
// done_o strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import gcr_pkg::*;

  // Mode codes 6 and 7 are not defined by the block; it must answer them
  // with an all-zero result and leave its state alone.
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  localparam int REQUEST_TARGET = 1450;
  // The slowest request is a last compare entry that walks all 64 stored entries.
  localparam int DRAIN_CYCLES   = 80;

  typedef struct packed {
    logic [CNT_W-1:0] value;
    logic             accepted;
    logic [1:0]       order;
    logic             order_valid;
  } reply_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [2:0]        mode_i;
  logic [NODE_W-1:0] node_i;
  logic [CNT_W-1:0]  amount_i;
  logic [NTOT_W-1:0] node_total_i;
  logic              last_i;
  logic              done_o;
  logic [CNT_W-1:0]  count_value_o;
  logic              accepted_o;
  logic [1:0]        order_o;
  logic              order_valid_o;

  grow_only_counter_replica dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .node_i        (node_i),
    .amount_i      (amount_i),
    .node_total_i  (node_total_i),
    .last_i        (last_i),
    .done_o        (done_o),
    .count_value_o (count_value_o),
    .accepted_o    (accepted_o),
    .order_o       (order_o),
    .order_valid_o (order_valid_o)
  );

  // Shadow copy of the replica. It is advanced once per accepted request,
  // in acceptance order, so it always matches what the block should hold.
  logic [CNT_W-1:0] shadow_counts [NODE_SLOTS];
  int               shadow_active;
  logic             saw_below;
  logic             saw_above;

  reply_t pending_replies[$];
  int     requests_sent;
  int     failures;
  logic   idle_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or never raises a strobe.
  initial begin
    #10_000_000;
    $display("[grow_only_counter_replica] ERROR");
    $finish;
  end

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  function automatic logic [CNT_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [NTOT_W-1:0] rand7();
    return NTOT_W'($urandom_range(0, 127));
  endfunction

  // Mostly an index inside the active range, so adds and reads do work;
  // the rest lands anywhere and exercises the reject path.
  function automatic logic [NODE_W-1:0] pick_node();
    if (shadow_active > 0 && $urandom_range(0, 9) < 8)
      return NODE_W'($urandom_range(0, shadow_active - 1));
    return NODE_W'($urandom_range(0, NODE_SLOTS - 1));
  endfunction

  // Most gaps are short, a few are long; idle_on switches whole stretches
  // of traffic to back-to-back requests.
  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Predicts the single result of one request and updates the shadow state.
  function automatic reply_t replica_step(input logic [2:0] mode,
                                          input logic [NODE_W-1:0] node,
                                          input logic [CNT_W-1:0] amount,
                                          input logic [NTOT_W-1:0] total,
                                          input logic tail);
    reply_t           r;
    int               limit;
    logic [CNT_W-1:0] mine;
    r = '0;
    limit = (int'(total) > NODE_SLOTS) ? NODE_SLOTS : int'(total);
    case (mode)
      MODE_CLEAR: begin
        foreach (shadow_counts[i]) shadow_counts[i] = '0;
        shadow_active = limit;
        saw_below = 1'b0;
        saw_above = 1'b0;
        r.accepted = 1'b1;
      end
      MODE_ADD: begin
        if (int'(node) < shadow_active) begin
          shadow_counts[node] = shadow_counts[node] + amount;
          r.accepted = 1'b1;
        end
      end
      MODE_READ: begin
        if (int'(node) < shadow_active) begin
          r.value = shadow_counts[node];
          r.accepted = 1'b1;
        end
      end
      MODE_TOTAL: begin
        for (int i = 0; i < shadow_active; i++) r.value = r.value + shadow_counts[i];
        r.accepted = 1'b1;
      end
      MODE_MERGE: begin
        // The node field is six bits wide, so every entry is in range.
        if (amount > shadow_counts[node]) shadow_counts[node] = amount;
        r.accepted = 1'b1;
        if (tail && limit > shadow_active) shadow_active = limit;
      end
      MODE_COMPARE: begin
        mine = (int'(node) < shadow_active) ? shadow_counts[node] : '0;
        if (mine < amount) saw_below = 1'b1;
        if (mine > amount) saw_above = 1'b1;
        if (tail) begin
          // Entries the other replica does not have count as zero there.
          for (int i = limit; i < shadow_active; i++)
            if (shadow_counts[i] != '0) saw_above = 1'b1;
          r.order = {saw_above, saw_below};
          r.order_valid = 1'b1;
          saw_below = 1'b0;
          saw_above = 1'b0;
        end
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Presents one request at a falling edge and holds it until a rising edge
  // sees start high with busy low. start is left high so that a following
  // request can go out without a dead cycle; a gap lowers it.
  task automatic send_request(input logic [2:0] mode, input logic [NODE_W-1:0] node,
                              input logic [CNT_W-1:0] amount,
                              input logic [NTOT_W-1:0] total, input logic tail);
    int gap;
    @(negedge clk_i);
    mode_i       <= mode;
    node_i       <= node;
    amount_i     <= amount;
    node_total_i <= total;
    last_i       <= tail;
    start        <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_replies.push_back(replica_step(mode, node, amount, total, tail));
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Every strobe is compared against the oldest prediction. Outputs are read
  // right at the rising edge, before the block's own updates of that edge.
  always @(posedge clk_i) begin : reply_check
    reply_t want;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        note_failure($sformatf("result with no request pending: value=%h acc=%b",
                               count_value_o, accepted_o));
      end else begin
        want = pending_replies.pop_front();
        if (count_value_o !== want.value || accepted_o !== want.accepted ||
            order_o !== want.order || order_valid_o !== want.order_valid)
          note_failure($sformatf({"result mismatch: expected value=%h acc=%b order=%0d ",
                                  "ov=%b, got value=%h acc=%b order=%0d ov=%b"},
                                 want.value, want.accepted, want.order,
                                 want.order_valid, count_value_o, accepted_o,
                                 order_o, order_valid_o));
      end
    end
  end

  // Clamping of the node count, wrap of a single count, the reject path of
  // add and read, and the two undefined mode codes.
  task automatic test_clear_and_bounds();
    send_request(MODE_CLEAR, 6'd0, 64'd0, 7'd127, 1'b0);
    send_request(MODE_ADD, 6'd63, '1, 7'd0, 1'b0);
    send_request(MODE_ADD, 6'd63, 64'd1, 7'd0, 1'b0);
    send_request(MODE_ADD, 6'd0, 64'd1, 7'd0, 1'b0);
    send_request(MODE_READ, 6'd63, '1, 7'd127, 1'b1);
    send_request(MODE_READ, 6'd0, 64'd0, 7'd0, 1'b0);
    send_request(MODE_TOTAL, 6'd0, 64'd0, 7'd0, 1'b0);
    send_request(MODE_CLEAR, 6'd63, '1, 7'd0, 1'b1);
    send_request(MODE_ADD, 6'd0, 64'd5, 7'd0, 1'b0);
    send_request(MODE_READ, 6'd0, 64'd0, 7'd0, 1'b0);
    send_request(MODE_TOTAL, 6'd63, '1, 7'd127, 1'b1);
    send_request(MODE_SPARE6, 6'd63, '1, 7'd127, 1'b1);
    send_request(MODE_SPARE7, 6'd21, rand64(), 7'd64, 1'b0);
  endtask

  // Merge raises counts to the maximum and the active count only upward.
  task automatic test_merge_streams();
    send_request(MODE_MERGE, 6'd5, 64'd100, 7'd0, 1'b0);
    send_request(MODE_MERGE, 6'd63, '1, 7'd64, 1'b1);
    send_request(MODE_MERGE, 6'd5, 64'd50, 7'd3, 1'b1);
    send_request(MODE_READ, 6'd63, 64'd0, 7'd0, 1'b0);
  endtask

  // All four orders, the walk over stored entries the other side lacks, and
  // a clear in the middle of a stream wiping the collected flags.
  task automatic test_compare_orders();
    send_request(MODE_COMPARE, 6'd5, 64'd100, 7'd0, 1'b0);
    send_request(MODE_COMPARE, 6'd63, '1, 7'd64, 1'b1);
    send_request(MODE_COMPARE, 6'd5, 64'd200, 7'd64, 1'b1);
    send_request(MODE_COMPARE, 6'd5, 64'd0, 7'd64, 1'b1);
    send_request(MODE_COMPARE, 6'd5, 64'd200, 7'd0, 1'b0);
    send_request(MODE_COMPARE, 6'd63, 64'd0, 7'd64, 1'b1);
    send_request(MODE_COMPARE, 6'd0, 64'd0, 7'd6, 1'b1);
    send_request(MODE_TOTAL, 6'd0, 64'd0, 7'd0, 1'b0);
    send_request(MODE_COMPARE, 6'd5, 64'd0, 7'd0, 1'b0);
    send_request(MODE_CLEAR, 6'd0, 64'd0, 7'd64, 1'b0);
    send_request(MODE_COMPARE, 6'd0, 64'd0, 7'd64, 1'b1);
  endtask

  task automatic run_clear();
    int roll;
    roll = $urandom_range(0, 3);
    if (roll == 0)
      send_request(MODE_CLEAR, pick_node(), rand64(), rand7(), 1'($urandom_range(0, 1)));
    else if (roll == 1)
      send_request(MODE_CLEAR, pick_node(), rand64(), 7'd64, 1'($urandom_range(0, 1)));
    else
      send_request(MODE_CLEAR, pick_node(), rand64(), NTOT_W'($urandom_range(1, 12)),
                   1'($urandom_range(0, 1)));
  endtask

  task automatic run_noise();
    logic [CNT_W-1:0] amt;
    amt = $urandom_range(0, 1) ? rand64() : CNT_W'($urandom_range(0, 15));
    send_request(3'($urandom_range(0, 7)), NODE_W'($urandom_range(0, 63)), amt,
                 rand7(), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_add_burst();
    int               n;
    int               roll;
    logic [CNT_W-1:0] amt;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 9);
      if (roll < 2) amt = 64'd1;
      else if (roll < 5) amt = CNT_W'($urandom_range(0, 1000));
      else if (roll == 5) amt = '1;
      else amt = rand64();
      send_request(MODE_ADD, pick_node(), amt, rand7(), 1'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(0, 3))
      send_request(MODE_READ, pick_node(), rand64(), rand7(), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) == 0)
      send_request(MODE_TOTAL, pick_node(), rand64(), rand7(), 1'($urandom_range(0, 1)));
  endtask

  // A short stream from another replica: values near ours so that the max
  // goes either way, and a random node count on the last entry.
  task automatic run_merge_stream();
    int                n;
    int                roll;
    logic [NODE_W-1:0] nd;
    logic [CNT_W-1:0]  amt;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      nd = $urandom_range(0, 1) ? pick_node() : NODE_W'($urandom_range(0, 63));
      roll = $urandom_range(0, 3);
      if (roll == 0) amt = shadow_counts[nd] + CNT_W'($urandom_range(0, 3));
      else if (roll == 1) amt = shadow_counts[nd] - CNT_W'($urandom_range(0, 3));
      else if (roll == 2) amt = CNT_W'($urandom_range(0, 5000));
      else amt = rand64();
      send_request(MODE_MERGE, nd, amt, rand7(), k == n - 1);
    end
  endtask

  // Streams our own entries back, perturbed so that each order shows up:
  // untouched gives equal, a raised entry gives before, a lowered one gives
  // after, both give concurrent, and a random variant mixes everything.
  task automatic run_compare_stream();
    int               other_n;
    int               entries;
    int               kind;
    int               hit_up;
    int               hit_down;
    logic [CNT_W-1:0] amt;
    other_n = ($urandom_range(0, 9) < 7) ? shadow_active : $urandom_range(0, 127);
    entries = (other_n > NODE_SLOTS) ? NODE_SLOTS : other_n;
    if (entries == 0) entries = 1;
    kind = $urandom_range(0, 4);
    hit_up = $urandom_range(0, entries - 1);
    hit_down = $urandom_range(0, entries - 1);
    for (int k = 0; k < entries; k++) begin
      if ($urandom_range(0, 19) == 0) run_noise();
      amt = (k < shadow_active) ? shadow_counts[k] : '0;
      if ((kind == 1 || kind == 3) && k == hit_up) amt = amt + CNT_W'($urandom_range(1, 6));
      if ((kind == 2 || kind == 3) && k == hit_down && amt != '0) amt = amt - 1;
      if (kind == 4 && $urandom_range(0, 1)) amt = rand64();
      send_request(MODE_COMPARE, NODE_W'(k), amt, NTOT_W'(other_n), k == entries - 1);
    end
  endtask

  task automatic test_random_traffic();
    int roll;
    while (requests_sent < REQUEST_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 19);
      if (roll == 0) run_clear();
      else if (roll <= 6) run_add_burst();
      else if (roll <= 10) run_merge_stream();
      else if (roll <= 16) run_compare_stream();
      else repeat ($urandom_range(1, 3)) run_noise();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    mode_i        = MODE_CLEAR;
    node_i        = '0;
    amount_i      = '0;
    node_total_i  = '0;
    last_i        = 1'b0;
    foreach (shadow_counts[i]) shadow_counts[i] = '0;
    shadow_active = 0;
    saw_below     = 1'b0;
    saw_above     = 1'b0;
    requests_sent = 0;
    failures      = 0;
    idle_on       = 1'b1;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_clear_and_bounds();
    test_merge_streams();
    test_compare_orders();
    test_random_traffic();

    // Drop start so the last request is not taken a second time.
    @(negedge clk_i);
    start <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_replies.size() != 0) note_failure("results still expected at the end");

    if (failures == 0) begin
      $display("[grow_only_counter_replica] OK");
    end else begin
      $display("[grow_only_counter_replica] ERROR");
    end
    $finish;
  end

endmodule
